// ===== design/rws_pkg.sv =====
// rws_pkg: shared types and codes for the roulette wheel selector
// op codes, status codes and the sequencer state type
// no dependencies
`default_nettype none

package rws_pkg;

    // operation codes on the input beat
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SPIN  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // status codes on the result beat
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SPIN,
        S_SEARCH,
        S_DONE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic ins;     // sorted insert happens this cycle
        logic active;  // cell holds a live entry
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/roulette_wheel_selector.sv =====
// roulette_wheel_selector: sorted fitness table with fitness-proportionate pick
// sequencer, shared 32x32 multiplier and a chain of rws_cell entries
// depends on rws_pkg and rws_cell
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_ready | i_op, i_fitness, i_tag, i_random_value
//  result  | o_valid | i_ready | o_selected_tag, o_status
//
// clear, add, no-op and a spin on an empty table go from idle straight to done: the
// insert is done by all cells at once.
// a spin steps through settle (only after reset or any clear or add), mul_lo, mul_hi,
// spin, search and done; settle waits for the running sums and search for the
// first-hit token rippling one cell per cycle down the chain.
// reset empties the table; one finished result may wait in the output register
// while the next beat is taken.
`default_nettype none

module roulette_wheel_selector #(
    parameter int MAX_ENTRIES  = 64,
    parameter int TAG_BITS     = 16,
    parameter int FITNESS_BITS = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire [1:0]                     i_op,
    input  wire signed [FITNESS_BITS-1:0] i_fitness,
    input  wire [TAG_BITS-1:0]            i_tag,
    input  wire [31:0]                    i_random_value,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [TAG_BITS-1:0]           o_selected_tag,
    output logic [1:0]                    o_status
);

    localparam int KEY_W = FITNESS_BITS;
    localparam int SUM_W = FITNESS_BITS + $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    rws_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_stale, n_stale;
    logic [KEY_W-1:0] r_min, n_min;
    logic [31:0]      r_rnd, n_rnd;
    logic [IDX_W-1:0] r_cyc, n_cyc;
    logic [63:0]      r_plo, n_plo;
    logic [63:0]      r_phi, n_phi;
    logic [SUM_W-1:0] r_spin, n_spin;
    logic             r_is_spin, n_is_spin;
    rws_pkg::t_status r_res_status, n_res_status;
    logic             r_ovalid, n_ovalid;
    logic [TAG_BITS-1:0] r_otag, n_otag;
    rws_pkg::t_status r_ostatus, n_ostatus;

    logic             accept;
    rws_pkg::t_op     op;
    logic [KEY_W-1:0] new_key;
    logic             full;
    logic             ins;
    logic [63:0]      total64;
    logic [31:0]      mult_b;
    logic [63:0]      prod;

    logic                c_keep [MAX_ENTRIES];
    logic [KEY_W-1:0]    c_key  [MAX_ENTRIES];
    logic [TAG_BITS-1:0] c_tag  [MAX_ENTRIES];
    logic [SUM_W-1:0]    c_sum  [MAX_ENTRIES];
    logic                c_fnd  [MAX_ENTRIES];
    logic [TAG_BITS-1:0] c_sel  [MAX_ENTRIES];

    // input decode; fitness kept offset-binary so unsigned compare sorts it
    always_comb begin
        accept  = i_valid && o_ready;
        op      = rws_pkg::t_op'(i_op);
        new_key = {~i_fitness[KEY_W-1], i_fitness[KEY_W-2:0]};
        full    = (r_count == CNT_W'(MAX_ENTRIES));
        ins     = accept && (op == rws_pkg::OP_ADD) && !full;
    end

    // shared multiplier: spin = rnd * hi + (rnd * lo) >> 32
    always_comb begin
        total64 = 64'(c_sum[MAX_ENTRIES-1]);
        mult_b  = (r_state == rws_pkg::S_MUL_LO) ? total64[31:0] : total64[63:32];
        prod    = 64'(r_rnd) * 64'(mult_b);
    end

    // chain of entry cells
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        rws_pkg::t_cell_ctl ctl;
        logic                prev_keep;
        logic [KEY_W-1:0]    prev_key;
        logic [TAG_BITS-1:0] prev_tag;
        logic [SUM_W-1:0]    prev_sum;
        logic                prev_fnd;
        logic [TAG_BITS-1:0] prev_sel;

        always_comb begin
            ctl.ins    = ins;
            ctl.active = (CNT_W'(gi) < r_count);
        end

        if (gi == 0) begin : g_head
            always_comb begin
                prev_keep = 1'b1;
                prev_key  = '0;
                prev_tag  = '0;
                prev_sum  = '0;
                prev_fnd  = 1'b0;
                prev_sel  = '0;
            end
        end else begin : g_body
            always_comb begin
                prev_keep = c_keep[gi-1];
                prev_key  = c_key[gi-1];
                prev_tag  = c_tag[gi-1];
                prev_sum  = c_sum[gi-1];
                prev_fnd  = c_fnd[gi-1];
                prev_sel  = c_sel[gi-1];
            end
        end

        rws_cell #(
            .KEY_W (KEY_W),
            .TAG_W (TAG_BITS),
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_new_key   (new_key),
            .i_new_tag   (i_tag),
            .i_min       (r_min),
            .i_spin      (r_spin),
            .i_prev_keep (prev_keep),
            .i_prev_key  (prev_key),
            .i_prev_tag  (prev_tag),
            .i_prev_sum  (prev_sum),
            .i_prev_fnd  (prev_fnd),
            .i_prev_sel  (prev_sel),
            .o_keep      (c_keep[gi]),
            .o_key       (c_key[gi]),
            .o_tag       (c_tag[gi]),
            .o_sum       (c_sum[gi]),
            .o_fnd       (c_fnd[gi]),
            .o_sel       (c_sel[gi])
        );
    end

    // sequencer: next state and datapath loads
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_stale      = r_stale;
        n_min        = r_min;
        n_rnd        = r_rnd;
        n_cyc        = r_cyc;
        n_plo        = r_plo;
        n_phi        = r_phi;
        n_spin       = r_spin;
        n_is_spin    = r_is_spin;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_ready;
        n_otag       = r_otag;
        n_ostatus    = r_ostatus;
        o_ready      = (r_state == rws_pkg::S_IDLE);

        unique case (r_state)
            rws_pkg::S_IDLE: begin
                if (accept) begin
                    n_is_spin    = 1'b0;
                    n_res_status = rws_pkg::ST_OK;
                    n_state      = rws_pkg::S_DONE;
                    unique case (op)
                        rws_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_stale = 1'b1;
                        end
                        rws_pkg::OP_ADD: begin
                            if (full) begin
                                n_res_status = rws_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                n_stale = 1'b1;
                                if ((r_count == '0) || (new_key < r_min)) begin
                                    n_min = new_key;
                                end
                            end
                        end
                        rws_pkg::OP_SPIN: begin
                            n_rnd = i_random_value;
                            n_cyc = '0;
                            if (r_count == '0) begin
                                n_res_status = rws_pkg::ST_EMPTY;
                            end else begin
                                n_is_spin = 1'b1;
                                n_state   = r_stale ? rws_pkg::S_SETTLE : rws_pkg::S_MUL_LO;
                            end
                        end
                        rws_pkg::OP_NOP: begin
                            n_res_status = rws_pkg::ST_OK;
                        end
                        default: begin
                            n_res_status = rws_pkg::ST_OK;
                        end
                    endcase
                end
            end
            rws_pkg::S_SETTLE: begin
                n_cyc = r_cyc + IDX_W'(1);
                if (r_cyc == LAST_IDX) begin
                    n_stale = 1'b0;
                    n_state = rws_pkg::S_MUL_LO;
                end
            end
            rws_pkg::S_MUL_LO: begin
                n_plo   = prod;
                n_state = rws_pkg::S_MUL_HI;
            end
            rws_pkg::S_MUL_HI: begin
                n_phi   = prod;
                n_state = rws_pkg::S_SPIN;
            end
            rws_pkg::S_SPIN: begin
                n_spin  = SUM_W'(r_phi + {32'b0, r_plo[63:32]});
                n_cyc   = '0;
                n_state = rws_pkg::S_SEARCH;
            end
            rws_pkg::S_SEARCH: begin
                n_cyc = r_cyc + IDX_W'(1);
                if (r_cyc == LAST_IDX) begin
                    n_state = rws_pkg::S_DONE;
                end
            end
            rws_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    if (r_is_spin) begin
                        n_otag = c_fnd[MAX_ENTRIES-1] ? c_sel[MAX_ENTRIES-1] : c_tag[0];
                    end else begin
                        n_otag = '0;
                    end
                    n_state = rws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rws_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rws_pkg::S_IDLE;
            r_count  <= '0;
            r_stale  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_stale  <= n_stale;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_min        <= n_min;
        r_rnd        <= n_rnd;
        r_cyc        <= n_cyc;
        r_plo        <= n_plo;
        r_phi        <= n_phi;
        r_spin       <= n_spin;
        r_is_spin    <= n_is_spin;
        r_res_status <= n_res_status;
        r_otag       <= n_otag;
        r_ostatus    <= n_ostatus;
    end

    assign o_valid        = r_ovalid;
    assign o_selected_tag = r_otag;
    assign o_status       = r_ostatus;

`ifndef SYNTHESIS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    // an add that fits grows the table by one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == rws_pkg::OP_ADD) && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("add did not grow the table");

    // the first two entries stay in descending order
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (c_key[0] >= c_key[1]))
        else $error("table head out of order");

    // a spin always finds an entry by the time its result is issued
    a_spin_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rws_pkg::S_DONE) && r_is_spin) |-> c_fnd[MAX_ENTRIES-1])
        else $error("spin finished without a hit");
`endif

endmodule

`default_nettype wire

// ===== design/rws_cell.sv =====
// rws_cell: one entry of the sorted selection chain
// holds key, tag, running sum and the first-hit token passed down the chain
// depends on rws_pkg
`default_nettype none

module rws_cell #(
    parameter int KEY_W = 32,
    parameter int TAG_W = 16,
    parameter int SUM_W = 38
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire rws_pkg::t_cell_ctl i_ctl,
    input  wire [KEY_W-1:0]        i_new_key,
    input  wire [TAG_W-1:0]        i_new_tag,
    input  wire [KEY_W-1:0]        i_min,
    input  wire [SUM_W-1:0]        i_spin,
    input  wire                    i_prev_keep,
    input  wire [KEY_W-1:0]        i_prev_key,
    input  wire [TAG_W-1:0]        i_prev_tag,
    input  wire [SUM_W-1:0]        i_prev_sum,
    input  wire                    i_prev_fnd,
    input  wire [TAG_W-1:0]        i_prev_sel,
    output logic                   o_keep,
    output logic [KEY_W-1:0]       o_key,
    output logic [TAG_W-1:0]       o_tag,
    output logic [SUM_W-1:0]       o_sum,
    output logic                   o_fnd,
    output logic [TAG_W-1:0]       o_sel
);

    logic [KEY_W-1:0] r_key, n_key;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_fnd, n_fnd;
    logic [TAG_W-1:0] r_sel, n_sel;
    logic             keep;
    logic [KEY_W-1:0] norm;
    logic             hit;

    // entry stays put when it sorts at or above the new key
    always_comb begin
        keep  = i_ctl.active && (r_key >= i_new_key);
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ins && !keep) begin
            n_key = i_prev_keep ? i_new_key : i_prev_key;
            n_tag = i_prev_keep ? i_new_tag : i_prev_tag;
        end
    end

    // running sum of normalized fitness, one cell per cycle
    always_comb begin
        norm  = i_ctl.active ? (r_key - i_min) : '0;
        n_sum = i_prev_sum + SUM_W'(norm);
    end

    // first-hit token: upstream hit wins, else this cell if its sum reaches spin
    always_comb begin
        hit   = i_ctl.active && (r_sum >= i_spin);
        n_fnd = i_prev_fnd || hit;
        n_sel = i_prev_fnd ? i_prev_sel : r_tag;
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
        r_sum <= n_sum;
        r_sel <= n_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fnd <= 1'b0;
        end else begin
            r_fnd <= n_fnd;
        end
    end

    assign o_keep = keep;
    assign o_key  = r_key;
    assign o_tag  = r_tag;
    assign o_sum  = r_sum;
    assign o_fnd  = r_fnd;
    assign o_sel  = r_sel;

endmodule

`default_nettype wire
